// ----- hdl/vfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Vector fixed-point ALU package
// Mode codes, axis codes, the stage payload type and the saturation helpers
// shared by the pipeline modules.
// ----------------------------------------------------------------------------
package vfa_pkg;

  // Operation codes carried on the mode input.
  localparam logic [3:0] MODE_ADD   = 4'd0;
  localparam logic [3:0] MODE_SUB   = 4'd1;
  localparam logic [3:0] MODE_CROSS = 4'd2;
  localparam logic [3:0] MODE_DOT   = 4'd3;
  localparam logic [3:0] MODE_SCALE = 4'd4;
  localparam logic [3:0] MODE_LEN   = 4'd5;
  localparam logic [3:0] MODE_NORM  = 4'd6;
  localparam logic [3:0] MODE_ORTHO = 4'd7;
  localparam logic [3:0] MODE_AXIS  = 4'd8;
  localparam logic [3:0] MODE_MAXN  = 4'd9;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic signed [31:0] word_t;

  localparam word_t Q_MAX = 32'sh7fffffff;
  localparam word_t Q_MIN = 32'sh80000000;

  localparam logic signed [65:0] LIM_HI = 66'sd2147483647;
  localparam logic signed [65:0] LIM_LO = -66'sd2147483648;

  // Payload that travels with each beat down the pipeline.
  typedef struct packed {
    logic [3:0] mode;
    word_t      rx;
    word_t      ry;
    word_t      rz;
    word_t      sc;
    logic [1:0] axis;
    logic       sat;
    word_t      vx;
    word_t      vy;
    word_t      vz;
  } pkt_t;

  // Clips a wide signed value to 32 bits; the top bit of the result is the clip flag.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > LIM_HI) begin
      res = {1'b1, Q_MAX};
    end else if (v < LIM_LO) begin
      res = {1'b1, Q_MIN};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  // Magnitude of a signed word, exact in 33 bits.
  function automatic logic [32:0] abs33(input word_t v);
    logic signed [32:0] e;
    e = {v[31], v};
    return v[31] ? 33'(-e) : 33'(e);
  endfunction

endpackage

// ----- hdl/vfa_front.sv -----
// ----------------------------------------------------------------------------
// Vector ALU front end
// Four register stages: input capture, component preparation, the six
// 32 x 32 multipliers, and the product sums with clipping.
// ----------------------------------------------------------------------------
module vfa_front import vfa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [3:0]  mode,
  input  word_t       a_x,
  input  word_t       a_y,
  input  word_t       a_z,
  input  word_t       b_x,
  input  word_t       b_y,
  input  word_t       b_z,
  input  word_t       factor,
  output logic        out_valid,
  output pkt_t        out_pkt,
  output logic [63:0] out_ssq
);

  // Stage one registers.
  logic       s1_valid;
  logic [3:0] s1_mode;
  word_t      s1_a [3];
  word_t      s1_b [3];
  word_t      s1_f;

  // Stage two registers.
  logic       s2_valid;
  logic [3:0] s2_mode;
  word_t      s2_a [3];
  word_t      s2_b [3];
  word_t      s2_f;
  word_t      s2_r [3];
  word_t      s2_sc;
  logic [1:0] s2_axis;
  logic       s2_sat;
  word_t      s2_v [3];

  // Stage three registers.
  logic              s3_valid;
  logic [3:0]        s3_mode;
  logic signed [63:0] s3_p [6];
  word_t             s3_r [3];
  word_t             s3_sc;
  logic [1:0]        s3_axis;
  logic              s3_sat;
  word_t             s3_v [3];

  // Stage two logic.
  logic [32:0] mag [3];
  logic [32:0] addc [3];
  logic [32:0] subc [3];
  logic [32:0] negc [3];
  logic [32:0] mx;
  logic [1:0]  j_axis;
  logic [1:0]  k_axis;
  word_t       c_vec [3];
  logic        c_sat;
  word_t       r_next [3];
  word_t       sc_next;
  logic [1:0]  axis_next;
  logic        sat_next;
  word_t       v_next [3];

  // Stage three logic.
  word_t ma [6];
  word_t mb [6];

  // Stage four logic.
  logic signed [65:0] dif [3];
  logic signed [65:0] dsum;
  logic [32:0]        crs [3];
  logic [32:0]        scl [3];
  logic [32:0]        dotc;
  pkt_t               pkt_next;

  // Capture the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_mode <= mode;
    s1_a[0] <= a_x;
    s1_a[1] <= a_y;
    s1_a[2] <= a_z;
    s1_b[0] <= b_x;
    s1_b[1] <= b_y;
    s1_b[2] <= b_z;
    s1_f    <= factor;
  end

  // Magnitudes, sums, largest axis and the orthogonal cross vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = abs33(s1_a[i]);
      addc[i] = sat32(66'(s1_a[i]) + 66'(s1_b[i]));
      subc[i] = sat32(66'(s1_a[i]) - 66'(s1_b[i]));
      negc[i] = sat32(66'sd0 - 66'(s1_a[i]));
    end
    if (mag[0] > mag[1]) begin
      j_axis = (mag[0] > mag[2]) ? AXIS_X : AXIS_Z;
    end else begin
      j_axis = (mag[1] > mag[2]) ? AXIS_Y : AXIS_Z;
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    // The unit axis sits just before the largest one, wrapping x to z.
    case (j_axis)
      AXIS_X:  k_axis = AXIS_Z;
      AXIS_Y:  k_axis = AXIS_X;
      default: k_axis = AXIS_Y;
    endcase
    case (k_axis)
      AXIS_X: begin
        c_vec[0] = '0;
        c_vec[1] = s1_a[2];
        c_vec[2] = negc[1][31:0];
        c_sat    = negc[1][32];
      end
      AXIS_Y: begin
        c_vec[0] = negc[2][31:0];
        c_vec[1] = '0;
        c_vec[2] = s1_a[0];
        c_sat    = negc[2][32];
      end
      default: begin
        c_vec[0] = s1_a[1];
        c_vec[1] = negc[0][31:0];
        c_vec[2] = '0;
        c_sat    = negc[0][32];
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      r_next[i] = '0;
      v_next[i] = s1_a[i];
    end
    sc_next   = '0;
    axis_next = AXIS_X;
    sat_next  = 1'b0;
    case (s1_mode)
      MODE_ADD: begin
        for (int i = 0; i < 3; i++) r_next[i] = addc[i][31:0];
        sat_next = addc[0][32] | addc[1][32] | addc[2][32];
      end
      MODE_SUB: begin
        for (int i = 0; i < 3; i++) r_next[i] = subc[i][31:0];
        sat_next = subc[0][32] | subc[1][32] | subc[2][32];
      end
      MODE_ORTHO: begin
        for (int i = 0; i < 3; i++) v_next[i] = c_vec[i];
        sat_next  = c_sat;
        axis_next = j_axis;
      end
      MODE_AXIS: begin
        axis_next = j_axis;
      end
      MODE_MAXN: begin
        // A magnitude of two to the 31 only comes from the most negative word.
        sc_next  = mx[31] ? Q_MAX : mx[31:0];
        sat_next = mx[31];
      end
      default: begin
        sat_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_mode <= s1_mode;
    s2_f    <= s1_f;
    s2_sc   <= sc_next;
    s2_axis <= axis_next;
    s2_sat  <= sat_next;
    for (int i = 0; i < 3; i++) begin
      s2_a[i] <= s1_a[i];
      s2_b[i] <= s1_b[i];
      s2_r[i] <= r_next[i];
      s2_v[i] <= v_next[i];
    end
  end

  // Multiplier operand selection; the length modes square the chosen vector.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (s2_mode)
      MODE_CROSS: begin
        ma[0] = s2_a[1]; mb[0] = s2_b[2];
        ma[1] = s2_a[2]; mb[1] = s2_b[1];
        ma[2] = s2_a[2]; mb[2] = s2_b[0];
        ma[3] = s2_a[0]; mb[3] = s2_b[2];
        ma[4] = s2_a[0]; mb[4] = s2_b[1];
        ma[5] = s2_a[1]; mb[5] = s2_b[0];
      end
      MODE_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = s2_a[i];
          mb[i] = s2_b[i];
        end
      end
      MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = s2_a[i];
          mb[i] = s2_f;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = s2_v[i];
          mb[i] = s2_v[i];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_mode <= s2_mode;
    s3_sc   <= s2_sc;
    s3_axis <= s2_axis;
    s3_sat  <= s2_sat;
    for (int i = 0; i < 6; i++) begin
      s3_p[i] <= ma[i] * mb[i];
    end
    for (int i = 0; i < 3; i++) begin
      s3_r[i] <= s2_r[i];
      s3_v[i] <= s2_v[i];
    end
  end

  // Product sums, the fixed-point shift and clipping.
  always_comb begin
    dif[0] = 66'(s3_p[0]) - 66'(s3_p[1]);
    dif[1] = 66'(s3_p[2]) - 66'(s3_p[3]);
    dif[2] = 66'(s3_p[4]) - 66'(s3_p[5]);
    dsum   = 66'(s3_p[0]) + 66'(s3_p[1]) + 66'(s3_p[2]);
    for (int i = 0; i < 3; i++) begin
      crs[i] = sat32(dif[i] >>> FRAC_BITS);
      scl[i] = sat32(66'(s3_p[i]) >>> FRAC_BITS);
    end
    dotc = sat32(dsum >>> FRAC_BITS);

    pkt_next.mode = s3_mode;
    pkt_next.rx   = s3_r[0];
    pkt_next.ry   = s3_r[1];
    pkt_next.rz   = s3_r[2];
    pkt_next.sc   = s3_sc;
    pkt_next.axis = s3_axis;
    pkt_next.sat  = s3_sat;
    pkt_next.vx   = s3_v[0];
    pkt_next.vy   = s3_v[1];
    pkt_next.vz   = s3_v[2];
    case (s3_mode)
      MODE_CROSS: begin
        pkt_next.rx  = crs[0][31:0];
        pkt_next.ry  = crs[1][31:0];
        pkt_next.rz  = crs[2][31:0];
        pkt_next.sat = crs[0][32] | crs[1][32] | crs[2][32];
      end
      MODE_DOT: begin
        pkt_next.sc  = dotc[31:0];
        pkt_next.sat = dotc[32];
      end
      MODE_SCALE: begin
        pkt_next.rx  = scl[0][31:0];
        pkt_next.ry  = scl[1][31:0];
        pkt_next.rz  = scl[2][31:0];
        pkt_next.sat = scl[0][32] | scl[1][32] | scl[2][32];
      end
      default: begin
        pkt_next.sat = s3_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s3_valid;
    end
    out_pkt <= pkt_next;
    out_ssq <= $unsigned(s3_p[0]) + $unsigned(s3_p[1]) + $unsigned(s3_p[2]);
  end

endmodule

// ----- hdl/vfa_sqrt.sv -----
// ----------------------------------------------------------------------------
// Vector ALU square root
// Pipelined restoring square root of a 64-bit radicand, one root bit per
// register stage, with a payload carried alongside.
// ----------------------------------------------------------------------------
module vfa_sqrt import vfa_pkg::*; #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  logic [PW-1:0] in_payload,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_payload
);

  localparam int NS = 32;

  logic          vld  [NS];
  logic [63:0]   rem  [NS];
  logic [31:0]   root [NS];
  logic [PW-1:0] pay  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic          cur_vld;
    logic [63:0]   cur_rem;
    logic [31:0]   cur_root;
    logic [PW-1:0] cur_pay;
    logic [63:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = in_rad;
      assign cur_root = '0;
      assign cur_pay  = in_payload;
    end else begin : g_next
      assign cur_vld  = vld[s-1];
      assign cur_rem  = rem[s-1];
      assign cur_root = root[s-1];
      assign cur_pay  = pay[s-1];
    end

    // The root bits found so far sit above the trial bit, so the trial is an OR.
    assign trial = (64'(cur_root) << (B + 1)) | (64'd1 << (2 * B));
    assign take  = (cur_rem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= cur_vld;
      end
      rem[s]  <= take ? (cur_rem - trial) : cur_rem;
      root[s] <= take ? (cur_root | (32'd1 << B)) : cur_root;
      pay[s]  <= cur_pay;
    end
  end

  assign out_valid   = vld[NS-1];
  assign out_root    = root[NS-1];
  assign out_payload = pay[NS-1];

endmodule

// ----- hdl/vfa_div.sv -----
// ----------------------------------------------------------------------------
// Vector ALU divider
// Three-lane pipelined restoring divider, one quotient bit per register
// stage, dividing the scaled component magnitudes by the vector length.
// ----------------------------------------------------------------------------
module vfa_div import vfa_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int PW        = 8,
  localparam int QW       = FRAC_BITS + 1,
  localparam int DW       = 32 + FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          in_len,
  input  logic [2:0][DW-1:0]   in_num,
  input  logic [PW-1:0]        in_payload,
  output logic                 out_valid,
  output logic [31:0]          out_len,
  output logic [2:0][QW-1:0]   out_quo,
  output logic [PW-1:0]        out_payload
);

  logic               vld [QW];
  logic [31:0]        len [QW];
  logic [2:0][DW-1:0] rem [QW];
  logic [2:0][QW-1:0] quo [QW];
  logic [PW-1:0]      pay [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic               cur_vld;
    logic [31:0]        cur_len;
    logic [2:0][DW-1:0] cur_rem;
    logic [2:0][QW-1:0] cur_quo;
    logic [PW-1:0]      cur_pay;
    logic [DW-1:0]      trial;

    if (s == 0) begin : g_first
      assign cur_vld = in_valid;
      assign cur_len = in_len;
      assign cur_rem = in_num;
      assign cur_quo = '0;
      assign cur_pay = in_payload;
    end else begin : g_next
      assign cur_vld = vld[s-1];
      assign cur_len = len[s-1];
      assign cur_rem = rem[s-1];
      assign cur_quo = quo[s-1];
      assign cur_pay = pay[s-1];
    end

    assign trial = DW'(cur_len) << B;

    // One compare and subtract per lane.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= cur_vld;
      end
      len[s] <= cur_len;
      pay[s] <= cur_pay;
      for (int i = 0; i < 3; i++) begin
        if (cur_rem[i] >= trial) begin
          rem[s][i] <= cur_rem[i] - trial;
          quo[s][i] <= cur_quo[i] | (QW'(1) << B);
        end else begin
          rem[s][i] <= cur_rem[i];
          quo[s][i] <= cur_quo[i];
        end
      end
    end
  end

  assign out_valid   = vld[QW-1];
  assign out_len     = len[QW-1];
  assign out_quo     = quo[QW-1];
  assign out_payload = pay[QW-1];

endmodule

// ----- hdl/vector3_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// Three-dimensional fixed-point vector ALU
// Add, subtract, cross, dot, scale, length, normalise, orthogonal unit
// vector, largest axis and max norm on signed fixed-point vectors.
// ----------------------------------------------------------------------------
// The unit takes one beat in every cycle and never raises busy. Each beat
// passes from start to done through four front-end stages, 32 square-root
// stages (one root bit each), FRAC_BITS + 1 divider stages (one quotient bit
// each) and the output register. Results come out in order and must be
// taken in the cycle in which done is high. The normalise threshold is
// written through the cfg channel, which is always ready; write it only
// while no beat is in flight.
module vector3_fixed_point_alu import vfa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode,
  input  word_t       a_x,
  input  word_t       a_y,
  input  word_t       a_z,
  input  word_t       b_x,
  input  word_t       b_y,
  input  word_t       b_z,
  input  word_t       factor,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data,
  output logic        done,
  output word_t       r_x,
  output word_t       r_y,
  output word_t       r_z,
  output word_t       scalar_out,
  output logic [1:0]  axis_index,
  output logic        saturated
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = 32 + FRAC_BITS;
  localparam int PW = $bits(pkt_t);
  localparam logic [QW-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [30:0] norm_threshold;

  logic        fe_valid;
  pkt_t        fe_pkt;
  logic [63:0] fe_ssq;

  logic          sq_valid;
  logic [31:0]   sq_root;
  logic [PW-1:0] sq_payload;
  pkt_t          sq_pkt;
  word_t         sq_v [3];
  logic [32:0]   sq_mag [3];
  logic [2:0][DW-1:0] div_num;

  logic               div_valid;
  logic [31:0]        div_len;
  logic [2:0][QW-1:0] div_quo;
  logic [PW-1:0]      div_payload;
  pkt_t               div_pkt;

  word_t      dv [3];
  word_t      nr [3];
  word_t      qz [3];
  logic       rescale;
  word_t      rx_next;
  word_t      ry_next;
  word_t      rz_next;
  word_t      sc_next;
  logic [1:0] axis_next;
  logic       sat_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      norm_threshold <= cfg_data;
    end
  end

  vfa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .mode      (mode),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .factor    (factor),
    .out_valid (fe_valid),
    .out_pkt   (fe_pkt),
    .out_ssq   (fe_ssq)
  );

  vfa_sqrt #(.PW(PW)) u_sqrt (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (fe_valid),
    .in_rad      (fe_ssq),
    .in_payload  (fe_pkt),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_payload (sq_payload)
  );

  // Scaled magnitudes as dividends for the normalise lanes.
  always_comb begin
    sq_pkt   = pkt_t'(sq_payload);
    sq_v[0]  = sq_pkt.vx;
    sq_v[1]  = sq_pkt.vy;
    sq_v[2]  = sq_pkt.vz;
    for (int i = 0; i < 3; i++) begin
      sq_mag[i]  = abs33(sq_v[i]);
      div_num[i] = {sq_mag[i][31:0], {FRAC_BITS{1'b0}}};
    end
  end

  vfa_div #(.FRAC_BITS(FRAC_BITS), .PW(PW)) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sq_valid),
    .in_len      (sq_root),
    .in_num      (div_num),
    .in_payload  (sq_payload),
    .out_valid   (div_valid),
    .out_len     (div_len),
    .out_quo     (div_quo),
    .out_payload (div_payload)
  );

  // Final result selection.
  always_comb begin
    div_pkt = pkt_t'(div_payload);
    dv[0]   = div_pkt.vx;
    dv[1]   = div_pkt.vy;
    dv[2]   = div_pkt.vz;
    rescale = (div_len > {1'b0, norm_threshold});
    for (int i = 0; i < 3; i++) begin
      qz[i] = {{(32 - QW){1'b0}}, div_quo[i]};
      if (rescale) begin
        nr[i] = dv[i][31] ? -qz[i] : qz[i];
      end else begin
        nr[i] = dv[i];
      end
    end
    rx_next   = div_pkt.rx;
    ry_next   = div_pkt.ry;
    rz_next   = div_pkt.rz;
    sc_next   = div_pkt.sc;
    axis_next = div_pkt.axis;
    sat_next  = div_pkt.sat;
    case (div_pkt.mode)
      MODE_LEN: begin
        sc_next  = div_len[31] ? Q_MAX : div_len;
        sat_next = div_len[31];
      end
      MODE_NORM, MODE_ORTHO: begin
        rx_next = nr[0];
        ry_next = nr[1];
        rz_next = nr[2];
      end
      default: begin
        sc_next = div_pkt.sc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    r_x        <= rx_next;
    r_y        <= ry_next;
    r_z        <= rz_next;
    scalar_out <= sc_next;
    axis_index <= axis_next;
    saturated  <= sat_next;
  end

`ifndef ASSERT_OFF
  // A reported axis is always one of the three real axes.
  a_axis_code: assert property (@(posedge clk) disable iff (rst)
    done |-> axis_index != 2'd3)
    else $error("axis index out of range");

  // A normalised component never exceeds one in magnitude.
  a_unit_quo: assert property (@(posedge clk) disable iff (rst)
    (div_valid && div_len != 32'd0 &&
     (div_pkt.mode == MODE_NORM || div_pkt.mode == MODE_ORTHO)) |->
    (div_quo[0] <= Q_ONE && div_quo[1] <= Q_ONE && div_quo[2] <= Q_ONE))
    else $error("normalise quotient above one");

  // A threshold write lands in the register on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> norm_threshold == $past(cfg_data))
    else $error("threshold write lost");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector fixed-point ALU testbench
// Drives directed and random vector beats through the ALU under several
// normalise thresholds. Every result is checked field by field, in order,
// against a behavioural predictor that uses exact wide arithmetic.
// ----------------------------------------------------------------------------
module tb;
  import vfa_pkg::*;

  localparam int  FRAC       = 16;
  localparam int  DRAIN_WAIT = FRAC + 44;
  localparam int  STALL_MAX  = 5000;
  localparam int  RAND_BEATS = 190;

  typedef struct {
    logic [3:0] op;
    word_t      ax, ay, az, bx, by, bz, fac;
    int         gap;
  } beat_t;

  typedef struct {
    word_t      rx, ry, rz, sc;
    logic [1:0] axis;
    logic       sat;
  } vec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  mode = '0;
  word_t       a_x = '0, a_y = '0, a_z = '0;
  word_t       b_x = '0, b_y = '0, b_z = '0;
  word_t       factor = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;
  logic        done;
  word_t       r_x, r_y, r_z, scalar_out;
  logic [1:0]  axis_index;
  logic        saturated;

  beat_t       pending_q[$];
  vec_result_t expected_q[$];
  beat_t       cur_beat;
  int          gap_left = 0;
  int          err_count = 0;
  int          stall_cycles = 0;
  longint      threshold = 0;

  vector3_fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
    .clk, .rst, .start, .busy, .mode, .a_x, .a_y, .a_z, .b_x, .b_y, .b_z,
    .factor, .cfg_valid, .cfg_ready, .cfg_data, .done, .r_x, .r_y, .r_z,
    .scalar_out, .axis_index, .saturated
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Clips an exact value to the signed 32-bit range and raises the flag.
  function automatic word_t clip_q(input logic signed [65:0] v, inout logic flag);
    if (v > 66'sd2147483647) begin
      flag = 1'b1;
      return Q_MAX;
    end
    if (v < -66'sd2147483648) begin
      flag = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Floor square root of a 64-bit unsigned value.
  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r = 0;
    longint unsigned probe = 64'h4000_0000_0000_0000;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= r + probe) begin
        x = x - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned length3(input longint x, input longint y,
                                              input longint z);
    longint unsigned s;
    s = x * x;
    s = s + y * y;
    s = s + z * z;
    return root64(s);
  endfunction

  // Rescales to unit length, or passes through when not above the threshold.
  function automatic void unit3(input longint v[3], inout logic flag,
                                output word_t r[3]);
    longint len;
    logic signed [65:0] w;
    len = longint'(length3(v[0], v[1], v[2]));
    for (int i = 0; i < 3; i++) begin
      if (len > threshold) begin
        w = (v[i] * 64'sd65536) / len;
        r[i] = clip_q(w, flag);
      end else begin
        r[i] = word_t'(v[i]);
      end
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 inout logic flag, output word_t r[3]);
    logic signed [65:0] p[3], q[3];
    for (int i = 0; i < 3; i++) begin
      p[i] = a[i];
      q[i] = b[i];
    end
    r[0] = clip_q((p[1] * q[2] - p[2] * q[1]) >>> FRAC, flag);
    r[1] = clip_q((p[2] * q[0] - p[0] * q[2]) >>> FRAC, flag);
    r[2] = clip_q((p[0] * q[1] - p[1] * q[0]) >>> FRAC, flag);
  endfunction

  // Largest magnitude axis; ties go towards z.
  function automatic logic [1:0] largest_axis(input longint v[3]);
    longint m[3];
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
    if (m[0] > m[1]) return m[0] > m[2] ? AXIS_X : AXIS_Z;
    return m[1] > m[2] ? AXIS_Y : AXIS_Z;
  endfunction

  // Works out the expected result of one beat.
  function automatic vec_result_t vec_predict(input beat_t bt);
    vec_result_t        res;
    longint             a[3], b[3], e[3], c[3], m;
    word_t              r[3], cw[3];
    logic signed [65:0] w;
    logic [1:0]         j;
    a = '{longint'(bt.ax), longint'(bt.ay), longint'(bt.az)};
    b = '{longint'(bt.bx), longint'(bt.by), longint'(bt.bz)};
    r = '{0, 0, 0};
    res.sc = '0;
    res.axis = AXIS_X;
    res.sat = 1'b0;
    case (bt.op)
      MODE_ADD: for (int i = 0; i < 3; i++) r[i] = clip_q(a[i] + b[i], res.sat);
      MODE_SUB: for (int i = 0; i < 3; i++) r[i] = clip_q(a[i] - b[i], res.sat);
      MODE_CROSS: cross3(a, b, res.sat, r);
      MODE_DOT: begin
        w = 0;
        for (int i = 0; i < 3; i++) w = w + 66'(a[i] * b[i]);
        res.sc = clip_q(w >>> FRAC, res.sat);
      end
      MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          w = a[i] * longint'(bt.fac);
          r[i] = clip_q(w >>> FRAC, res.sat);
        end
      end
      MODE_LEN: begin
        w = {2'b00, length3(a[0], a[1], a[2])};
        res.sc = clip_q(w, res.sat);
      end
      MODE_NORM: unit3(a, res.sat, r);
      MODE_ORTHO: begin
        j = largest_axis(a);
        e = '{0, 0, 0};
        e[j == AXIS_X ? 2 : j - 1] = 64'sd65536;
        cross3(a, e, res.sat, cw);
        for (int i = 0; i < 3; i++) c[i] = longint'(cw[i]);
        unit3(c, res.sat, r);
        res.axis = j;
      end
      MODE_AXIS: res.axis = largest_axis(a);
      MODE_MAXN: begin
        m = 0;
        for (int i = 0; i < 3; i++) begin
          if ((a[i] < 0 ? -a[i] : a[i]) > m) m = a[i] < 0 ? -a[i] : a[i];
        end
        res.sc = clip_q(m, res.sat);
      end
      default: ;
    endcase
    res.rx = r[0];
    res.ry = r[1];
    res.rz = r[2];
    return res;
  endfunction

  // Driver: presents queued beats, holds each until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) expected_q.push_back(vec_predict(cur_beat));
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_beat = pending_q.pop_front();
          mode <= cur_beat.op;
          a_x <= cur_beat.ax;
          a_y <= cur_beat.ay;
          a_z <= cur_beat.az;
          b_x <= cur_beat.bx;
          b_y <= cur_beat.by;
          b_z <= cur_beat.bz;
          factor <= cur_beat.fac;
          gap_left <= cur_beat.gap;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    err_count++;
  endtask

  // Monitor: each result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    vec_result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (r_x !== want.rx) report("r_x", r_x, want.rx);
        if (r_y !== want.ry) report("r_y", r_y, want.ry);
        if (r_z !== want.rz) report("r_z", r_z, want.rz);
        if (scalar_out !== want.sc) report("scalar_out", scalar_out, want.sc);
        if (axis_index !== want.axis) report("axis_index", axis_index, want.axis);
        if (saturated !== want.sat) report("saturated", saturated, want.sat);
      end
    end
  end

  // Watchdog on cycles in which no beat of any kind is taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      7: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 0;
          3: return -1;
          4: return 1;
          default: return 32'sh0001_0000;
        endcase
      end
      8: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000;
    endcase
  endfunction

  task automatic add_beat(input logic [3:0] op, input word_t ax, input word_t ay,
                          input word_t az, input word_t bx, input word_t by,
                          input word_t bz, input word_t fac, input int gap);
    beat_t bt;
    bt = '{op: op, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, fac: fac, gap: gap};
    pending_q.push_back(bt);
  endtask

  task automatic write_threshold(input logic [30:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_q.size() != 0 || start || gap_left != 0 || expected_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Stimulus: phases under several thresholds, directed beats first.
  initial begin
    logic [30:0] thr_set[4];
    logic [3:0]  op;
    bit          burst;
    localparam word_t ONE = 32'sh0001_0000;
    thr_set = '{31'd0, 31'h7fff_ffff, 31'h0001_0000, 31'($urandom)};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (thr_set[p]) begin
      write_threshold(thr_set[p]);
      if (p == 0) begin
        add_beat(MODE_ADD, Q_MAX, Q_MIN, 5, Q_MAX, Q_MIN, -9, 0, 0);
        add_beat(MODE_SUB, Q_MIN, Q_MAX, 0, 1, -1, Q_MIN, 0, 0);
        add_beat(MODE_CROSS, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, 0, 1);
        add_beat(MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 0);
        add_beat(MODE_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 2);
        add_beat(MODE_DOT, -1, 3, -5, 7, -1, 1, 0, 0);
        add_beat(MODE_SCALE, Q_MIN, Q_MAX, -3, 0, 0, 0, Q_MIN, 0);
        add_beat(MODE_SCALE, -1, 1, ONE, 0, 0, 0, -1, 3);
        add_beat(MODE_LEN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0);
        add_beat(MODE_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0);
        add_beat(MODE_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0);
        add_beat(MODE_NORM, 0, 0, 0, 0, 0, 0, 0, 1);
        add_beat(MODE_NORM, 1, -1, 0, 0, 0, 0, 0, 0);
        add_beat(MODE_ORTHO, 5, 5, 5, 0, 0, 0, 0, 0);
        add_beat(MODE_ORTHO, 0, 0, 0, 0, 0, 0, 0, 0);
        add_beat(MODE_ORTHO, Q_MIN, 2, -7, 0, 0, 0, 0, 4);
        add_beat(MODE_ORTHO, 1, -ONE, 2, 0, 0, 0, 0, 0);
        add_beat(MODE_AXIS, -9, 9, 1, 0, 0, 0, 0, 0);
        add_beat(MODE_AXIS, 4, 4, -4, 0, 0, 0, 0, 0);
        add_beat(MODE_AXIS, 8, -2, 3, 0, 0, 0, 0, 0);
        add_beat(MODE_MAXN, Q_MIN, 0, 1, 0, 0, 0, 0, 0);
        add_beat(MODE_MAXN, 0, -6, Q_MAX, 0, 0, 0, 0, 0);
        for (int m = 10; m < 16; m++) add_beat(4'(m), Q_MAX, -1, 7, -1, 3, 9, 5, 0);
      end
      burst = 1'b0;
      for (int n = 0; n < RAND_BEATS; n++) begin
        if (n % 40 == 0) burst = $urandom_range(0, 2) == 0;
        op = $urandom_range(0, 9) == 0 ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, 9));
        add_beat(op, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), burst ? 0 : $urandom_range(0, 10));
      end
      wait_drained();
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
